// ===== rtl/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the lfu cache table
// Sizes, opcodes and the packed layout of one stored entry.
// ----------------------------------------------------------------------------
`default_nettype none

package lfu_pkg;

	localparam int ENTRIES    = 16;
	localparam int COUNT_BITS = 16;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);
	localparam int KEY_W      = 32;
	localparam int DATA_W     = 32;
	localparam int CAP_W      = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [DATA_W-1:0]     data;
		logic [COUNT_BITS-1:0] count;
		logic [IDX_W-1:0]      rank;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/lfu_if.sv =====
// ----------------------------------------------------------------------------
// lfu_req_if / lfu_rsp_if: request and response channels
// Valid/ready channels carrying one access and one result.
// ----------------------------------------------------------------------------
`default_nettype none

interface lfu_req_if;
	logic                       valid;
	logic                       ready;
	logic                       opcode;
	logic [lfu_pkg::KEY_W-1:0]  key;
	logic [lfu_pkg::DATA_W-1:0] value;

	modport source (output valid, opcode, key, value, input ready);
	modport sink   (input valid, opcode, key, value, output ready);
endinterface

interface lfu_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       hit;
	logic [lfu_pkg::DATA_W-1:0] read_value;
	logic                       evicted;
	logic [lfu_pkg::KEY_W-1:0]  evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
	input  wire logic [WIDTH-1:0]                 wr_data,
	input  wire logic                             rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
	output logic      [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_table_top.sv =====
// Each access that changes state sweeps the entry ram twice through its single
// read port: one sweep to find the key and the victim, one read-modify-write
// sweep to update ranks. A get miss or an ignored put needs only the first sweep.
// A new access is taken only once the last result has gone to the result
// register, which waits for the receiver, so one access is handled at a time.
// Reset (arst_n low) empties the cache and sets the capacity register to 16.
// ----------------------------------------------------------------------------
// lfu_cache_table_top: lfu key/value cache with lru tie break
// Entries live in one ram; valid bits, occupancy and control in flops.
// ----------------------------------------------------------------------------
`default_nettype none

module lfu_cache_table_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	lfu_req_if.sink                        req,
	lfu_rsp_if.source                      rsp,
	input  wire logic                      cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata
);

	localparam int IDX_W = lfu_pkg::IDX_W;
	localparam int OCC_W = lfu_pkg::OCC_W;
	localparam int CNT_W = IDX_W + 1;
	localparam int CMP_W = lfu_pkg::CAP_W + OCC_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_UPD    = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_TOUCH = 2'd1;
	localparam logic [1:0] MODE_INS   = 2'd2;

	localparam logic [lfu_pkg::CAP_W-1:0] CAP_RESET_V = lfu_pkg::CAP_RESET;

	logic [2:0]                    state_q;
	logic [1:0]                    mode_q;
	logic [lfu_pkg::CAP_W-1:0]     cap_q;
	logic [OCC_W-1:0]              occ_q;
	logic [lfu_pkg::ENTRIES-1:0]   valid_q;
	logic [CNT_W-1:0]              rd_idx_q;
	logic                          rd_vld_s1;
	logic [IDX_W-1:0]              idx_s1;

	logic                          op_q;
	logic [lfu_pkg::KEY_W-1:0]     key_q;
	logic [lfu_pkg::DATA_W-1:0]    val_q;

	logic                          found_q;
	logic [IDX_W-1:0]              match_idx_q;
	lfu_pkg::entry_t               match_ent_q;
	logic                          have_v_q;
	logic [IDX_W-1:0]              vic_idx_q;
	lfu_pkg::entry_t               vic_ent_q;
	logic                          evict_q;
	logic [IDX_W-1:0]              ins_idx_q;

	logic                          pend_hit_q;
	logic [lfu_pkg::DATA_W-1:0]    pend_rval_q;
	logic                          pend_ev_q;
	logic [lfu_pkg::KEY_W-1:0]     pend_evkey_q;

	logic                          out_valid_q;
	logic                          rsp_hit_q;
	logic [lfu_pkg::DATA_W-1:0]    rsp_rval_q;
	logic                          rsp_ev_q;
	logic [lfu_pkg::KEY_W-1:0]     rsp_evkey_q;

	logic                          ram_we;
	logic [IDX_W-1:0]              ram_waddr;
	logic [lfu_pkg::ENTRY_W-1:0]   ram_wdata;
	logic                          ram_re;
	logic [lfu_pkg::ENTRY_W-1:0]   ram_rdata;
	lfu_pkg::entry_t               rd_ent;
	lfu_pkg::entry_t               upd_ent;
	logic                          upd_we;

	logic                          rd_more;
	logic                          last_s1;
	logic                          cur_valid;
	logic                          is_match;
	logic                          is_better;

	logic                          cap_zero;
	logic                          full;
	logic                          do_evict;
	logic [lfu_pkg::ENTRIES-1:0]   valid_after;
	logic [lfu_pkg::ENTRIES-1:0]   valid_next;
	logic                          free_found;
	logic [IDX_W-1:0]              free_idx;
	logic [1:0]                    mode_d;

	lfu_ram #(
		.WIDTH (lfu_pkg::ENTRY_W),
		.DEPTH (lfu_pkg::ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	// read sweep control
	assign rd_more   = rd_idx_q < CNT_W'(lfu_pkg::ENTRIES);
	assign ram_re    = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && rd_more;
	assign last_s1   = rd_vld_s1 && (idx_s1 == IDX_W'(lfu_pkg::ENTRIES - 1));
	assign rd_ent    = lfu_pkg::entry_t'(ram_rdata);
	assign cur_valid = valid_q[idx_s1];

	// key match and victim compare on the entry being read
	assign is_match  = cur_valid && (rd_ent.key == key_q) && !found_q;
	assign is_better = cur_valid && (!have_v_q || (rd_ent.count < vic_ent_q.count) ||
		((rd_ent.count == vic_ent_q.count) && (rd_ent.rank > vic_ent_q.rank)));

	// decision after the scan
	assign cap_zero = (cap_q == '0);
	assign full     = (CMP_W'(occ_q) >= CMP_W'(cap_q)) ||
		(occ_q == OCC_W'(lfu_pkg::ENTRIES));
	assign do_evict = full && have_v_q;

	always_comb begin
		valid_after = valid_q;
		if (do_evict) begin
			valid_after[vic_idx_q] = 1'b0;
		end
	end

	// lowest free slot once the victim is gone
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
			if (!valid_after[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// valid bits after an insert
	always_comb begin
		valid_next           = valid_after;
		valid_next[free_idx] = 1'b1;
	end

	always_comb begin
		mode_d = MODE_NONE;
		if (found_q && ((op_q == lfu_pkg::OP_GET) || !cap_zero)) begin
			mode_d = MODE_TOUCH;
		end else if (!found_q && (op_q == lfu_pkg::OP_PUT) && !cap_zero && free_found) begin
			mode_d = MODE_INS;
		end
	end

	// read-modify-write of one entry in the update sweep
	always_comb begin
		upd_ent = rd_ent;
		upd_we  = 1'b0;
		unique case (mode_q)
			MODE_TOUCH: begin
				if (idx_s1 == match_idx_q) begin
					upd_we       = 1'b1;
					upd_ent.rank = '0;
					if (!(&rd_ent.count)) begin
						upd_ent.count = rd_ent.count + 1'b1;
					end
					if (op_q == lfu_pkg::OP_PUT) begin
						upd_ent.data = val_q;
					end
				end else if (cur_valid && (rd_ent.rank < match_ent_q.rank)) begin
					upd_we       = 1'b1;
					upd_ent.rank = rd_ent.rank + 1'b1;
				end
			end
			MODE_INS: begin
				if (idx_s1 == ins_idx_q) begin
					upd_we        = 1'b1;
					upd_ent.key   = key_q;
					upd_ent.data  = val_q;
					upd_ent.count = lfu_pkg::COUNT_BITS'(1);
					upd_ent.rank  = '0;
				end else if (cur_valid) begin
					upd_we = 1'b1;
					if (evict_q && (rd_ent.rank > vic_ent_q.rank)) begin
						upd_ent.rank = rd_ent.rank;
					end else begin
						upd_ent.rank = rd_ent.rank + 1'b1;
					end
				end
			end
			default: begin
				upd_we = 1'b0;
			end
		endcase
	end

	assign ram_we    = (state_q == ST_UPD) && rd_vld_s1 && upd_we;
	assign ram_waddr = idx_s1;
	assign ram_wdata = upd_ent;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET_V;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// sequencer, valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_NONE;
			occ_q     <= '0;
			valid_q   <= '0;
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
			have_v_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= ram_re;
			if (ram_re) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						have_v_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (rd_vld_s1) begin
						if (is_match) begin
							found_q <= 1'b1;
						end
						if (is_better) begin
							have_v_q <= 1'b1;
						end
					end
					if (last_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					mode_q   <= mode_d;
					rd_idx_q <= '0;
					if (mode_d == MODE_INS) begin
						valid_q <= valid_next;
						if (!do_evict) begin
							occ_q <= occ_q + 1'b1;
						end
					end
					state_q <= (mode_d == MODE_NONE) ? ST_DONE : ST_UPD;
				end
				ST_UPD: begin
					if (last_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// access and scan payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && req.valid) begin
			op_q  <= req.opcode;
			key_q <= req.key;
			val_q <= req.value;
		end
		if ((state_q == ST_SCAN) && rd_vld_s1) begin
			if (is_match) begin
				match_idx_q <= idx_s1;
				match_ent_q <= rd_ent;
			end
			if (is_better) begin
				vic_idx_q <= idx_s1;
				vic_ent_q <= rd_ent;
			end
		end
		if (ram_re) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (state_q == ST_DECIDE) begin
			evict_q      <= do_evict && (mode_d == MODE_INS);
			ins_idx_q    <= free_idx;
			pend_hit_q   <= found_q;
			pend_rval_q  <= (found_q && (op_q == lfu_pkg::OP_GET)) ? match_ent_q.data : '0;
			pend_ev_q    <= do_evict && (mode_d == MODE_INS);
			pend_evkey_q <= (do_evict && (mode_d == MODE_INS)) ? vic_ent_q.key : '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || rsp.ready)) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || rsp.ready)) begin
			rsp_hit_q   <= pend_hit_q;
			rsp_rval_q  <= pend_rval_q;
			rsp_ev_q    <= pend_ev_q;
			rsp_evkey_q <= pend_evkey_q;
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rval_q;
	assign rsp.evicted     = rsp_ev_q;
	assign rsp.evicted_key = rsp_evkey_q;

	// occupancy tracks the valid bits
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		OCC_W'($countones(valid_q)) == occ_q)
		else $error("occupancy out of step with valid bits");

	// an insert never lands on a live slot
	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) && (mode_d == MODE_INS) |-> !valid_after[free_idx])
		else $error("insert onto a valid slot");

	// an eviction only comes from a put that missed
	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> !rsp.hit && (rsp.read_value == '0))
		else $error("eviction reported on a hit");

	// ram is only written during the update sweep
	a_wr_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (mode_q != MODE_NONE))
		else $error("entry write without an update");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: lfu cache table check
// Drives gets and puts over the request channel, predicts hit, value and
// eviction with a behavioral lfu/lru cache, and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   ENTRIES    = lfu_pkg::ENTRIES;
	localparam int   COUNT_BITS = lfu_pkg::COUNT_BITS;
	localparam int   KEY_W      = lfu_pkg::KEY_W;
	localparam int   DATA_W     = lfu_pkg::DATA_W;
	localparam int   CAP_W      = lfu_pkg::CAP_W;
	localparam logic OP_GET     = lfu_pkg::OP_GET;
	localparam logic OP_PUT     = lfu_pkg::OP_PUT;

	localparam int COUNT_TOP   = (1 << COUNT_BITS) - 1;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} outcome_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lfu_req_if req ();
	lfu_rsp_if rsp ();

	lfu_cache_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req.sink),
		.rsp       (rsp.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// cache model state
	bit               slot_used [ENTRIES];
	bit [KEY_W-1:0]   slot_key  [ENTRIES];
	bit [DATA_W-1:0]  slot_data [ENTRIES];
	int               slot_hits [ENTRIES];
	int               slot_age  [ENTRIES];
	int               fill_level;
	int               capacity;

	outcome_t pending_outcomes [$];
	int       errors = 0;
	int       idle_cycles = 0;
	int       send_idle_pct;
	int       recv_stall_pct;
	bit [KEY_W-1:0] key_pool [$];

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("lfu_cache_table_top verification failed");
			$finish;
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (!arst_n)
			rsp.ready <= 1'b0;
		else
			rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				$display("%0t: unexpected result hit=%0b val=%h ev=%0b evk=%h", $time,
					rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key);
			end else begin
				want = pending_outcomes[0];
				pending_outcomes.delete(0);
				if (rsp.hit !== want.hit) begin
					errors++;
					$display("%0t: hit exp %0b got %0b", $time, want.hit, rsp.hit);
				end
				if (rsp.read_value !== want.read_value) begin
					errors++;
					$display("%0t: read_value exp %h got %h", $time, want.read_value,
						rsp.read_value);
				end
				if (rsp.evicted !== want.evicted) begin
					errors++;
					$display("%0t: evicted exp %0b got %0b", $time, want.evicted,
						rsp.evicted);
				end
				if (rsp.evicted_key !== want.evicted_key) begin
					errors++;
					$display("%0t: evicted_key exp %h got %h", $time, want.evicted_key,
						rsp.evicted_key);
				end
			end
		end
	end

	function automatic int lookup_slot(bit [KEY_W-1:0] k);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_key[i] == k)
				return i;
		return -1;
	endfunction

	// make a slot most recent and count a use
	function automatic void mark_used(int s);
		int r;
		r = slot_age[s];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i] && slot_age[i] < r)
				slot_age[i]++;
		slot_age[s] = 0;
		if (slot_hits[s] < COUNT_TOP)
			slot_hits[s]++;
	endfunction

	// apply one access to the model and return the result it should give
	function automatic outcome_t cache_access(logic op, bit [KEY_W-1:0] k,
			bit [DATA_W-1:0] v);
		outcome_t o;
		int cap, s, victim, r;
		o = '0;
		cap = (capacity > ENTRIES) ? ENTRIES : capacity;
		s = lookup_slot(k);
		o.hit = (s >= 0);
		if (op == OP_GET) begin
			if (s >= 0) begin
				o.read_value = slot_data[s];
				mark_used(s);
			end
			return o;
		end
		if (cap == 0)
			return o;
		if (s >= 0) begin
			slot_data[s] = v;
			mark_used(s);
			return o;
		end
		if (fill_level >= cap) begin
			victim = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && (victim < 0 || slot_hits[i] < slot_hits[victim] ||
						(slot_hits[i] == slot_hits[victim] &&
						 slot_age[i] > slot_age[victim])))
					victim = i;
			if (victim >= 0) begin
				o.evicted = 1'b1;
				o.evicted_key = slot_key[victim];
				r = slot_age[victim];
				slot_used[victim] = 1'b0;
				for (int i = 0; i < ENTRIES; i++)
					if (slot_used[i] && slot_age[i] > r)
						slot_age[i]--;
				if (fill_level > 0)
					fill_level--;
			end
		end
		s = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (!slot_used[i]) begin
				s = i;
				break;
			end
		if (s < 0)
			return o;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_used[i])
				slot_age[i]++;
		slot_used[s] = 1'b1;
		slot_key[s]  = k;
		slot_data[s] = v;
		slot_hits[s] = 1;
		slot_age[s]  = 0;
		fill_level++;
		return o;
	endfunction

	// send one access, predicting its result at the transfer
	task automatic send_access(logic op, bit [KEY_W-1:0] k, bit [DATA_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct)
			@(negedge clk);
		req.valid  = 1'b1;
		req.opcode = op;
		req.key    = k;
		req.value  = v;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		pending_outcomes.insert(pending_outcomes.size(), cache_access(op, k, v));
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic drain_results();
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// capacity is written only while idle
	task automatic set_capacity(int c);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= CAP_W'(c);
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity = c;
	endtask

	function automatic bit [KEY_W-1:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(99) < 85)
			return key_pool[$urandom_range(key_pool.size() - 1)];
		return $urandom();
	endfunction

	task automatic test_directed();
		send_access(OP_GET, 32'h0, 32'h0);
		send_access(OP_PUT, 32'h0, 32'hFFFF_FFFF);
		send_access(OP_PUT, 32'hFFFF_FFFF, 32'h0);
		send_access(OP_GET, 32'h0, 32'h1234_5678);
		send_access(OP_GET, 32'hFFFF_FFFF, 32'h0);
		send_access(OP_PUT, 32'h0, 32'hA5A5_5A5A);
		send_access(OP_GET, 32'h0, 32'h0);
		// capacity two: lfu eviction of the least used entry
		set_capacity(2);
		send_access(OP_PUT, 32'h10, 32'h1);
		send_access(OP_PUT, 32'h20, 32'h2);
		send_access(OP_PUT, 32'h30, 32'h3);
		send_access(OP_GET, 32'h30, 32'h0);
		send_access(OP_PUT, 32'h40, 32'h4);
		// capacity zero ignores puts
		set_capacity(0);
		send_access(OP_PUT, 32'h50, 32'h5);
		send_access(OP_PUT, 32'h30, 32'h6);
		send_access(OP_GET, 32'h30, 32'h0);
		// capacity above entries acts as entries
		set_capacity(31);
		for (int i = 0; i < 8; i++)
			send_access(OP_PUT, 32'h100 + i, $urandom());
	endtask

	// one heavily used key at capacity one, then a put of a new key
	task automatic test_hot_key();
		set_capacity(1);
		send_access(OP_PUT, 32'hCAFE, 32'h1);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 40; i++)
			send_access(OP_GET, 32'hCAFE, 32'h0);
		send_access(OP_PUT, 32'hBEEF, 32'h2);
	endtask

	task automatic test_random(int n, int sidle, int rstall);
		int c;
		logic op;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 49 && $urandom_range(3) == 0) begin
				c = $urandom_range(16);
				if ($urandom_range(9) == 0)
					c = $urandom_range(31, 17);
				set_capacity(c);
			end
			op = 1'($urandom_range(1));
			send_access(op, pick_key(), $urandom());
			if (key_pool.size() < 24 && $urandom_range(3) == 0)
				key_pool.insert(key_pool.size(), $urandom());
		end
	endtask

	initial begin
		capacity = 16;
		fill_level = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			slot_used[i] = 0;
			slot_hits[i] = 0;
			slot_age[i]  = 0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.opcode = OP_GET;
		req.key = '0;
		req.value = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_random(200, 0, 0);
		test_random(200, 50, 0);
		drain_results();
		test_random(200, 0, 50);
		test_random(200, 35, 35);
		set_capacity(16);
		test_hot_key();
		drain_results();

		if (errors == 0)
			$display("lfu_cache_table_top verification clean");
		else
			$display("lfu_cache_table_top verification failed");
		$finish;
	end

endmodule

`default_nettype wire
